FILE: hdl/ffc_pkg.sv
// Shared types and constants of the float format converter.
package ffc_pkg;

   typedef enum logic [1:0] {
      CMD_F32_TO_BF16 = 2'd0,
      CMD_BF16_TO_F32 = 2'd1,
      CMD_F32_TO_F16  = 2'd2,
      CMD_F16_TO_F32  = 2'd3
   } cmd_type;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned HALF_W   = 16;
   localparam int unsigned F32_BIAS = 127;
   localparam int unsigned F16_BIAS = 15;

   localparam logic [7:0] EXP_REBIAS   = 8'(F32_BIAS - F16_BIAS);
   localparam logic [7:0] F16_SUB_BASE = 8'(F32_BIAS - F16_BIAS + 1);
   localparam logic [7:0] F16_UNDER    = 8'(F32_BIAS - F16_BIAS - 10);
   localparam logic [7:0] F16_OVER     = 8'(F32_BIAS - F16_BIAS + 30);
   localparam logic [7:0] F32_EXP_ONES = 8'hff;
   localparam logic [4:0] F16_EXP_ONES = 5'h1f;

   localparam logic [30:0] F32_INF_ABS   = 31'h7f800000;
   localparam logic [15:0] BF16_QUIET    = 16'h0040;
   localparam logic [15:0] BF16_HALF_ULP = 16'h8000;
   localparam logic [9:0]  F16_QUIET     = 10'h200;

   typedef logic [WORD_W-1:0] word_type;

endpackage

FILE: hdl/ffc_req_if.sv
// Request channel carrying a command and a source bit pattern.
interface ffc_req_if
   import ffc_pkg::*;
   ();
   logic     valid;
   logic     ready;
   cmd_type  cmd;
   word_type operand_bits;

   modport source (output valid, output cmd, output operand_bits, input ready);
   modport sink   (input valid, input cmd, input operand_bits, output ready);
endinterface

FILE: hdl/ffc_rsp_if.sv
// Response channel carrying the converted bit pattern.
interface ffc_rsp_if
   import ffc_pkg::*;
   ();
   logic     valid;
   logic     ready;
   word_type result_bits;

   modport source (output valid, output result_bits, input ready);
   modport sink   (input valid, input result_bits, output ready);
endinterface

FILE: hdl/float_format_converter_top.sv
// Top level of the float format converter: input register, conversion, result register.
//
// Usage:
//   req_if carries a two-bit command and a 32-bit source word; rsp_if returns
//   one converted 32-bit word per request, in request order. Commands select
//   fp32->bf16 (round to nearest even), bf16->fp32, fp32->fp16 (truncating)
//   and fp16->fp32. 16-bit sources sit in the low half; 16-bit results come
//   back in the low half with the upper half zero.
//   A request passes through the input register, then through the conversion
//   logic into the result register. Throughput is one word per cycle, set by
//   the single conversion pass with no loop, while the receiver keeps
//   rsp_if.ready high.
//   Reset empties both registers; no response is pending afterward.
//   When the receiver stalls, the result register holds its word, the input
//   register fills behind it, and req_if.ready drops only when both are full.
module float_format_converter_top
   import ffc_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   ffc_req_if.sink   req_if,
   ffc_rsp_if.source rsp_if
);

   logic     in_valid_ff, in_valid_in;
   cmd_type  in_cmd_ff;
   word_type in_bits_ff;
   logic     out_valid_ff, out_valid_in;
   word_type out_bits_ff;
   word_type conv_bits;
   logic     out_advance;
   logic     in_advance;

   ffc_convert u_convert (
      .cmd          (in_cmd_ff),
      .operand_bits (in_bits_ff),
      .result_bits  (conv_bits)
   );

   assign out_advance = !out_valid_ff || rsp_if.ready;
   assign in_advance  = !in_valid_ff || out_advance;
   assign req_if.ready = in_advance;

   assign in_valid_in  = in_advance ? req_if.valid : in_valid_ff;
   assign out_valid_in = out_advance ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_advance) begin
         in_cmd_ff  <= req_if.cmd;
         in_bits_ff <= req_if.operand_bits;
      end
      if (out_advance) begin
         out_bits_ff <= conv_bits;
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.result_bits = out_bits_ff;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_if.valid && !in_valid_ff)
      else $error("pipeline not empty after reset");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> in_valid_ff)
      else $error("accepted word lost at input register");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_advance |=> in_valid_ff && $stable(in_bits_ff))
      else $error("stalled input word dropped");

   a_half_upper_zero: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && (in_cmd_ff == CMD_F32_TO_BF16 || in_cmd_ff == CMD_F32_TO_F16)
      |-> conv_bits[31:16] == 16'd0)
      else $error("16-bit result with nonzero upper half");

endmodule

FILE: hdl/ffc_convert.sv
// Combinational conversion between fp32, bf16 and fp16 bit patterns.
module ffc_convert
   import ffc_pkg::*;
(
   input  cmd_type  cmd,
   input  word_type operand_bits,
   output word_type result_bits
);

   logic        sign32;
   logic [7:0]  exp8;
   logic [22:0] frac23;
   logic [9:0]  man10;

   logic [15:0] bf16_res;
   logic        bf16_up;
   logic [15:0] f16_res;
   logic [7:0]  sub_diff;
   logic [3:0]  sub_shamt;
   logic [10:0] sub_val;
   logic [7:0]  f16_exp8;

   logic        h_sign;
   logic [4:0]  h_exp;
   logic [9:0]  h_man;
   logic [3:0]  lead_pos;
   logic [3:0]  norm_shift;
   logic [9:0]  norm_man;
   logic [7:0]  norm_exp;
   word_type    f32_res;

   assign sign32 = operand_bits[31];
   assign exp8   = operand_bits[30:23];
   assign frac23 = operand_bits[22:0];
   assign man10  = operand_bits[22:13];

   // fp32 to bf16, round to nearest even
   assign bf16_up = (operand_bits[15:0] > BF16_HALF_ULP) ||
                    ((operand_bits[15:0] == BF16_HALF_ULP) && operand_bits[16]);

   always_comb begin
      if (operand_bits[30:0] > F32_INF_ABS) begin
         bf16_res = operand_bits[31:16] | BF16_QUIET;
      end else if (exp8 == 8'd0) begin
         bf16_res = {sign32, 15'd0};
      end else begin
         bf16_res = operand_bits[31:16] + {15'd0, bf16_up};
      end
   end

   // fp32 to fp16, truncating
   assign sub_diff  = F16_SUB_BASE - exp8;
   assign sub_shamt = sub_diff[3:0];
   assign sub_val   = {1'b1, man10} >> sub_shamt;
   assign f16_exp8  = exp8 - EXP_REBIAS;

   always_comb begin
      if (exp8 < F16_UNDER) begin
         f16_res = {sign32, 15'd0};
      end else if (exp8 < F16_SUB_BASE) begin
         f16_res = {sign32, 5'd0, sub_val[9:0]};
      end else if (exp8 == F32_EXP_ONES) begin
         if (frac23 == 23'd0) begin
            f16_res = {sign32, F16_EXP_ONES, 10'd0};
         end else begin
            f16_res = {sign32, F16_EXP_ONES, man10 | F16_QUIET};
         end
      end else if (exp8 > F16_OVER) begin
         f16_res = {sign32, F16_EXP_ONES, 10'd0};
      end else begin
         f16_res = {sign32, f16_exp8[4:0], man10};
      end
   end

   // fp16 to fp32, normalize subnormals
   assign h_sign = operand_bits[15];
   assign h_exp  = operand_bits[14:10];
   assign h_man  = operand_bits[9:0];

   always_comb begin
      lead_pos = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (h_man[i]) begin
            lead_pos = 4'(i);
         end
      end
   end

   assign norm_shift = 4'd10 - lead_pos;
   assign norm_man   = h_man << norm_shift;
   assign norm_exp   = F16_SUB_BASE - {4'd0, norm_shift};

   always_comb begin
      if (h_exp == 5'd0) begin
         if (h_man == 10'd0) begin
            f32_res = {h_sign, 31'd0};
         end else begin
            f32_res = {h_sign, norm_exp, norm_man, 13'd0};
         end
      end else if (h_exp == F16_EXP_ONES) begin
         f32_res = {h_sign, F32_EXP_ONES, h_man, 13'd0};
      end else begin
         f32_res = {h_sign, {3'd0, h_exp} + EXP_REBIAS, h_man, 13'd0};
      end
   end

   always_comb begin
      unique case (cmd)
         CMD_F32_TO_BF16: result_bits = {16'd0, bf16_res};
         CMD_BF16_TO_F32: result_bits = {operand_bits[15:0], 16'd0};
         CMD_F32_TO_F16:  result_bits = {16'd0, f16_res};
         CMD_F16_TO_F32:  result_bits = f32_res;
         default:         result_bits = '0;
      endcase
   end

endmodule

FILE: bench/tb_float_format_converter_top.sv
// Self-checking testbench for float_format_converter_top with a built-in conversion predictor.
module tb_float_format_converter_top
   import ffc_pkg::*;
   ;

   timeunit 1ns;
   timeprecision 1ps;

   logic clock;
   logic reset;

   ffc_req_if req_chan ();
   ffc_rsp_if rsp_chan ();

   float_format_converter_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   word_type expected_words[$];
   int       mismatch_count = 0;
   int       stall_left     = 0;
   bit       sender_steady  = 1'b0;
   bit       sink_steady    = 1'b0;
   word_type expected_word;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("float_format_converter_top verification failed");
      $finish;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   function automatic logic [15:0] fp32_to_bf16(word_type bits);
      logic round_up;
      if (bits[30:0] > 31'h7f800000) return bits[31:16] | 16'h0040;
      if (bits[30:23] == 8'h00) return {bits[31], 15'h0000};
      round_up = (bits[15:0] > 16'h8000) || (bits[15:0] == 16'h8000 && bits[16]);
      return bits[31:16] + {15'h0000, round_up};
   endfunction

   function automatic logic [15:0] fp32_to_fp16(word_type bits);
      logic        sign;
      int          exp_f16;
      logic [9:0]  frac;
      logic [10:0] denorm;
      sign    = bits[31];
      exp_f16 = int'(bits[30:23]) - 112;
      frac    = bits[22:13];
      if (exp_f16 <= 0) begin
         if (exp_f16 < -10) return {sign, 15'h0000};
         denorm = {1'b1, frac} >> (1 - exp_f16);
         return {sign, 4'h0, denorm};
      end
      if (exp_f16 == 143) begin
         if (bits[22:0] == 23'h0) return {sign, 5'h1f, 10'h000};
         return {sign, 5'h1f, frac | 10'h200};
      end
      if (exp_f16 > 30) return {sign, 5'h1f, 10'h000};
      return {sign, exp_f16[4:0], frac};
   endfunction

   function automatic word_type fp16_to_fp32(logic [15:0] half);
      logic        sign;
      logic [4:0]  exp_f16;
      logic [10:0] frac;
      int          shift;
      sign    = half[15];
      exp_f16 = half[14:10];
      frac    = {1'b0, half[9:0]};
      shift   = 0;
      if (exp_f16 == 5'h00) begin
         if (frac == 11'h000) return {sign, 31'h0};
         while (!frac[10] && shift < 11) begin
            frac  = frac << 1;
            shift = shift + 1;
         end
         return {sign, 8'(113 - shift), frac[9:0], 13'h0000};
      end
      if (exp_f16 == 5'h1f) return {sign, 8'hff, frac[9:0], 13'h0000};
      return {sign, 8'(exp_f16) + 8'd112, frac[9:0], 13'h0000};
   endfunction

   function automatic word_type convert_word(cmd_type op, word_type bits);
      case (op)
         CMD_F32_TO_BF16: return {16'h0000, fp32_to_bf16(bits)};
         CMD_BF16_TO_F32: return {bits[15:0], 16'h0000};
         CMD_F32_TO_F16:  return {16'h0000, fp32_to_fp16(bits)};
         default:         return fp16_to_fp32(bits[15:0]);
      endcase
   endfunction

   function automatic word_type random_operand(cmd_type op);
      word_type bits;
      bits = $urandom();
      if ($urandom_range(0, 3) == 0) return bits;
      if (op == CMD_F32_TO_BF16 || op == CMD_F32_TO_F16) begin
         case ($urandom_range(0, 5))
            0:       bits[30:23] = 8'h00;
            1:       bits[30:23] = 8'hff;
            2:       bits[30:23] = 8'(101 + $urandom_range(0, 13));
            3:       bits[30:23] = 8'(141 + $urandom_range(0, 3));
            4:       bits[30:23] = 8'(253 + $urandom_range(0, 1));
            default: ;
         endcase
         if ($urandom_range(0, 3) == 0) bits[15:0] = 16'h8000;
         if ($urandom_range(0, 5) == 0) bits[22:16] = 7'h7f;
         if ($urandom_range(0, 7) == 0) bits[22:0] = 23'h0;
      end else begin
         case ($urandom_range(0, 3))
            0:       bits[14:10] = 5'h00;
            1:       bits[14:10] = 5'h1f;
            default: ;
         endcase
         if ($urandom_range(0, 3) == 0) bits[9:0] = 10'(1 << $urandom_range(0, 9));
         if ($urandom_range(0, 7) == 0) bits[9:0] = 10'h000;
      end
      return bits;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_words.size() == 0) begin
            $error("result_bits: expected none, got %h", rsp_chan.result_bits);
            mismatch_count++;
         end else begin
            expected_word = expected_words.pop_front();
            if (rsp_chan.result_bits !== expected_word) begin
               $error("result_bits: expected %h, got %h", expected_word, rsp_chan.result_bits);
               mismatch_count++;
            end
         end
      end
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (sink_steady) begin
         rsp_chan.ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_chan.ready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   task automatic send_word(input cmd_type op, input word_type bits);
      int gap;
      gap = sender_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.cmd          <= op;
      req_chan.operand_bits <= bits;
      do @(posedge clock); while (!req_chan.ready);
      expected_words.push_back(convert_word(op, bits));
   endtask

   task automatic idle_until_drained();
      req_chan.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_cases();
      send_word(CMD_F32_TO_BF16, 32'h7f800001);
      send_word(CMD_F32_TO_BF16, 32'h80000000);
      send_word(CMD_F32_TO_BF16, 32'h807fffff);
      send_word(CMD_F32_TO_BF16, 32'h3f808000);
      send_word(CMD_F32_TO_BF16, 32'h3f818000);
      send_word(CMD_F32_TO_BF16, 32'h3f808001);
      send_word(CMD_F32_TO_BF16, 32'h7f7fffff);
      send_word(CMD_BF16_TO_F32, 32'hffffffff);
      send_word(CMD_BF16_TO_F32, 32'h00000000);
      send_word(CMD_F32_TO_F16,  32'h7f800000);
      send_word(CMD_F32_TO_F16,  32'hff800001);
      send_word(CMD_F32_TO_F16,  32'h47800000);
      send_word(CMD_F32_TO_F16,  32'h477fe000);
      send_word(CMD_F32_TO_F16,  32'hb3000000);
      send_word(CMD_F32_TO_F16,  32'h32ffffff);
      send_word(CMD_F32_TO_F16,  32'h387fe000);
      send_word(CMD_F32_TO_F16,  32'h00000000);
      send_word(CMD_F16_TO_F32,  32'h00000001);
      send_word(CMD_F16_TO_F32,  32'h000083ff);
      send_word(CMD_F16_TO_F32,  32'h00007c00);
      send_word(CMD_F16_TO_F32,  32'h0000fe01);
      send_word(CMD_F16_TO_F32,  32'h00007bff);
      send_word(CMD_F16_TO_F32,  32'hffff0000);
   endtask

   task automatic test_random_conversions(input int count);
      cmd_type op;
      for (int n = 0; n < count; n++) begin
         op = cmd_type'($urandom_range(0, 3));
         send_word(op, random_operand(op));
      end
   endtask

   task automatic test_back_to_back(input int count);
      sender_steady = 1'b1;
      sink_steady   = 1'b1;
      test_random_conversions(count);
      sender_steady = 1'b0;
      sink_steady   = 1'b0;
   endtask

   task automatic test_receiver_backpressure(input int count);
      sender_steady = 1'b1;
      test_random_conversions(count);
      sender_steady = 1'b0;
   endtask

   task automatic test_drain_pauses(input int rounds, input int count);
      for (int r = 0; r < rounds; r++) begin
         test_random_conversions(count);
         idle_until_drained();
      end
   endtask

   initial begin
      clock                 = 1'b0;
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.cmd         <= CMD_F32_TO_BF16;
      req_chan.operand_bits <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_random_conversions(500);
      test_back_to_back(300);
      test_receiver_backpressure(300);
      test_drain_pauses(5, 40);

      idle_until_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("float_format_converter_top verification clean");
      end else begin
         $display("float_format_converter_top verification failed");
      end
      $finish;
   end

endmodule
